// File: src/kufef_pkg.sv
// Package for the union-find edge filter: sizes, widths and limits.
// No dependencies.
package kufef_pkg;
    localparam int NODES       = 1024;
    localparam int NODE_BITS   = $clog2(NODES);
    localparam int ID_BITS     = 11;
    localparam int LENGTH_BITS = 16;
    localparam int LEN_PORT    = 16;
    localparam int RANK_BITS   = 4;
    localparam int COUNT_BITS  = 10;
    localparam logic [RANK_BITS-1:0]  RANK_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ID_BITS-1:0]    NODE_COUNT_RESET = ID_BITS'(1024);
endpackage

// File: src/kruskal_union_find_edge_filter_unit.sv
// Kruskal edge filter: union-find with path compression and union by rank.
// Uses kufef_pkg. Parent and rank tables are single-port memories in this module.
//
// An item (edge) passes through these steps: a forest clear on start_set
// sweeps all NODES table entries, one per cycle; each find walks the parent
// chain with a registered memory read per hop, then writes each node below
// the root on the path once more for compression; the union reads both root
// ranks and links the roots. The single table port sets the rate, and no new
// edge is taken before the last one is through. After reset the block clears
// its tables first before it takes the first item; configuration writes are always taken.
module kruskal_union_find_edge_filter_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [kufef_pkg::ID_BITS-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic start_set,
    input  logic [kufef_pkg::ID_BITS-1:0] from_node,
    input  logic [kufef_pkg::ID_BITS-1:0] to_node,
    input  logic [kufef_pkg::LEN_PORT-1:0] edge_length,
    output logic out_valid,
    input  logic out_stall,
    output logic accepted,
    output logic [kufef_pkg::COUNT_BITS-1:0] accepted_count,
    output logic [kufef_pkg::LEN_PORT-1:0] max_length,
    output logic id_error,
    output logic order_error
);
    import kufef_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_WALK_RD, S_WALK_CMP, S_COMP_RD, S_COMP_WR,
        S_RANK_A, S_RANK_B, S_UNION, S_DONE
    } state_t;

    typedef logic [NODE_BITS-1:0] node_t;

    node_t              parent_mem [NODES];
    logic [RANK_BITS-1:0] rank_mem [NODES];

    state_t state_reg;
    logic [ID_BITS-1:0] node_count_reg;
    node_t clr_reg, from_reg, to_reg, cur_reg, root_reg, root_a_reg;
    logic second_reg;
    logic clr_item_reg;
    logic [LENGTH_BITS-1:0] len_reg, prev_reg, last_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [RANK_BITS-1:0] rank_a_reg;
    logic [RANK_BITS-1:0] rank_b_reg;
    logic id_err_reg, ord_err_reg, acc_reg, out_valid_reg;
    node_t p_rd;
    logic [RANK_BITS-1:0] r_rd;

    // Single-port table access, address and write chosen by the sequencer.
    node_t mem_addr;
    logic  p_we, r_we;
    node_t p_wd;
    logic [RANK_BITS-1:0] r_wd;

    logic [ID_BITS-1:0] limit;
    logic id_bad;
    logic [LENGTH_BITS-1:0] in_len;
    logic [LENGTH_BITS-1:0] prev_eff;

    assign limit = (node_count_reg > ID_BITS'(NODES)) ? ID_BITS'(NODES) : node_count_reg;
    assign in_len = edge_length[LENGTH_BITS-1:0];

    always_comb
    begin
        mem_addr = cur_reg;
        p_we = 1'b0;
        r_we = 1'b0;
        p_wd = root_reg;
        r_wd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_addr = clr_reg;
                p_we = 1'b1;
                r_we = 1'b1;
                p_wd = clr_reg;
            end
            S_WALK_RD: mem_addr = root_reg;
            S_COMP_WR:
            begin
                p_we = (cur_reg != root_reg);
            end
            S_RANK_A: mem_addr = root_a_reg;
            S_RANK_B: mem_addr = root_reg;
            S_UNION:
            begin
                // Higher rank wins; on a tie the from root goes under the to root.
                if (rank_a_reg > r_rd)
                begin
                    mem_addr = root_reg;
                    p_we = 1'b1;
                    p_wd = root_a_reg;
                end
                else
                begin
                    mem_addr = root_a_reg;
                    p_we = 1'b1;
                    p_wd = root_reg;
                end
            end
            S_DONE:
            begin
                mem_addr = root_reg;
                r_we = acc_reg && (rank_a_reg == rank_b_reg) && (rank_b_reg != RANK_MAX)
                       && (state_reg == S_DONE) && !out_valid_reg;
                r_wd = rank_b_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            parent_mem[mem_addr] <= p_wd;
        if (r_we)
            rank_mem[mem_addr] <= r_wd;
        p_rd <= parent_mem[mem_addr];
        r_rd <= rank_mem[mem_addr];
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign accepted = acc_reg;
    assign accepted_count = total_reg;
    assign max_length = LEN_PORT'(last_reg);
    assign id_error = id_err_reg;
    assign order_error = ord_err_reg;

    always_comb
    begin
        id_bad = 1'b0;
        if (from_node == '0 || from_node > limit || to_node == '0 || to_node > limit)
            id_bad = 1'b1;
    end
    assign prev_eff = start_set ? '0 : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_count_reg <= NODE_COUNT_RESET;
            clr_reg <= '0;
            clr_item_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg <= '0;
            last_reg <= '0;
            prev_reg <= '0;
            acc_reg <= 1'b0;
            id_err_reg <= 1'b0;
            ord_err_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    // The clear after reset has no edge waiting behind it.
                    if (clr_reg == node_t'(NODES - 1))
                        state_reg <= !clr_item_reg ? S_IDLE
                                                   : ((id_err_reg) ? S_DONE : S_CHECK);
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        id_err_reg <= id_bad;
                        ord_err_reg <= in_len < prev_eff;
                        len_reg <= in_len;
                        from_reg <= node_t'(from_node - 1'b1);
                        to_reg <= node_t'(to_node - 1'b1);
                        acc_reg <= 1'b0;
                        second_reg <= 1'b0;
                        if (start_set)
                        begin
                            total_reg <= '0;
                            last_reg <= '0;
                            prev_reg <= '0;
                            clr_reg <= '0;
                            clr_item_reg <= 1'b1;
                            state_reg <= S_CLEAR;
                        end
                        else
                            state_reg <= id_bad ? S_DONE : S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // Start a find on the current endpoint.
                    cur_reg <= second_reg ? to_reg : from_reg;
                    root_reg <= second_reg ? to_reg : from_reg;
                    state_reg <= S_WALK_RD;
                end
                S_WALK_RD:
                begin
                    cur_reg <= root_reg;
                    state_reg <= S_WALK_CMP;
                end
                S_WALK_CMP:
                begin
                    if (p_rd == root_reg)
                    begin
                        cur_reg <= second_reg ? to_reg : from_reg;
                        state_reg <= S_COMP_RD;
                    end
                    else
                    begin
                        root_reg <= p_rd;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_COMP_RD:
                    state_reg <= S_COMP_WR;
                S_COMP_WR:
                begin
                    // p_rd holds the old parent of cur; overwrite it with the root.
                    if (cur_reg == root_reg)
                    begin
                        if (!second_reg)
                        begin
                            root_a_reg <= root_reg;
                            second_reg <= 1'b1;
                            state_reg <= S_CHECK;
                        end
                        else if (root_a_reg == root_reg)
                        begin
                            prev_reg <= len_reg;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_RANK_A;
                    end
                    else
                    begin
                        cur_reg <= p_rd;
                        state_reg <= S_COMP_RD;
                    end
                end
                S_RANK_A:
                    state_reg <= S_RANK_B;
                S_RANK_B:
                begin
                    rank_a_reg <= r_rd;
                    state_reg <= S_UNION;
                end
                S_UNION:
                begin
                    rank_b_reg <= r_rd;
                    acc_reg <= 1'b1;
                    if (total_reg != COUNT_MAX)
                        total_reg <= total_reg + 1'b1;
                    last_reg <= len_reg;
                    prev_reg <= len_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("ready while busy");
    a_acc_no_iderr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(acc_reg && id_err_reg)) else $error("accepted with bad id");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNION) |=> (total_reg != '0)) else $error("count not advanced");
endmodule
